// ===== design/led_matrix_scan_pwm_driver_macros.svh =====
// ---------------------------------------------------------------------------
// LED matrix scan driver assertion macros
// Shorthand for concurrent checks clocked on clk_i, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef LED_MATRIX_SCAN_PWM_DRIVER_MACROS_SVH
`define LED_MATRIX_SCAN_PWM_DRIVER_MACROS_SVH

// property must hold at every edge out of reset
`define LMSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen
`define LMSD_NEVER(lbl, cond, msg) `LMSD_ASSERT(lbl, !(cond), msg)

`endif

// ===== design/lmsd_pkg.sv =====
// ---------------------------------------------------------------------------
// LED matrix scan driver package
// Shared defaults, codes and request/result structs.
// ---------------------------------------------------------------------------
package lmsd_pkg;

  localparam int PANEL_COLUMNS = 32;
  localparam int SCAN_ROWS     = 16;
  localparam int PWM_LEVELS    = 8;
  localparam int CHANNEL_BITS  = 8;

  // fixed field widths of the ports
  localparam int ROW_FIELD_W   = 5;
  localparam int COL_FIELD_W   = 5;
  localparam int LEVEL_FIELD_W = 8;
  localparam int ADDR_FIELD_W  = 4;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
  localparam logic [RES_CNT_W-1:0] RES_FULL = RES_CNT_W'(RES_DEPTH);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } opcode_e;

  typedef enum logic {
    KIND_COLUMN = 1'b0,
    KIND_LATCH  = 1'b1
  } kind_e;

  typedef struct packed {
    logic                     is_tick;
    logic                     in_range;
    logic [ROW_FIELD_W-1:0]   pixel_row;
    logic [COL_FIELD_W-1:0]   pixel_column;
    logic [LEVEL_FIELD_W-1:0] red;
    logic [LEVEL_FIELD_W-1:0] green;
    logic [LEVEL_FIELD_W-1:0] blue;
  } cmd_t;

  typedef struct packed {
    kind_e                   kind;
    logic                    upper_red;
    logic                    upper_green;
    logic                    upper_blue;
    logic                    lower_red;
    logic                    lower_green;
    logic                    lower_blue;
    logic [ADDR_FIELD_W-1:0] row_address;
    logic                    last;
  } res_t;

endpackage

// ===== design/lmsd_front.sv =====
// ---------------------------------------------------------------------------
// LED matrix scan driver front end
// Takes requests, classifies them and queues them for the back end.
// ---------------------------------------------------------------------------
module lmsd_front #(
  parameter int PANEL_COLUMNS = lmsd_pkg::PANEL_COLUMNS,
  parameter int SCAN_ROWS     = lmsd_pkg::SCAN_ROWS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  logic                                 hold_i,
  input  logic                                 opcode_i,
  input  logic [lmsd_pkg::ROW_FIELD_W-1:0]     pixel_row_i,
  input  logic [lmsd_pkg::COL_FIELD_W-1:0]     pixel_column_i,
  input  logic [lmsd_pkg::LEVEL_FIELD_W-1:0]   red_level_i,
  input  logic [lmsd_pkg::LEVEL_FIELD_W-1:0]   green_level_i,
  input  logic [lmsd_pkg::LEVEL_FIELD_W-1:0]   blue_level_i,
  output logic                                 full_o,
  output logic                                 cmd_valid_o,
  output lmsd_pkg::cmd_t                       cmd_o,
  input  logic                                 cmd_pop_i
);

  localparam int PTR_W = $clog2(lmsd_pkg::CMD_DEPTH);
  localparam int CNT_W = $clog2(lmsd_pkg::CMD_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(lmsd_pkg::CMD_DEPTH);

  lmsd_pkg::cmd_t         queue_q [lmsd_pkg::CMD_DEPTH];
  logic [PTR_W-1:0]       wptr_q, wptr_d;
  logic [PTR_W-1:0]       rptr_q, rptr_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   accept;
  lmsd_pkg::cmd_t         cmd_new;

  assign full_o      = (cnt_q == CNT_FULL) || hold_i;
  assign accept      = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rptr_q];

  // classify: tick or write, and whether the write lands on the panel
  always_comb begin
    cmd_new.is_tick      = (opcode_i == lmsd_pkg::OP_TICK);
    cmd_new.in_range     = (32'(pixel_row_i) < 2 * SCAN_ROWS) &&
                           (32'(pixel_column_i) < PANEL_COLUMNS);
    cmd_new.pixel_row    = pixel_row_i;
    cmd_new.pixel_column = pixel_column_i;
    cmd_new.red          = red_level_i;
    cmd_new.green        = green_level_i;
    cmd_new.blue         = blue_level_i;
  end

  always_comb begin
    wptr_d = accept ? PTR_W'((32'(wptr_q) + 1) % lmsd_pkg::CMD_DEPTH) : wptr_q;
    rptr_d = cmd_pop_i ? PTR_W'((32'(rptr_q) + 1) % lmsd_pkg::CMD_DEPTH) : rptr_q;
    cnt_d  = cnt_q + CNT_W'(accept) - CNT_W'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      queue_q[wptr_q] <= cmd_new;
    end
  end

endmodule

// ===== design/lmsd_back.sv =====
// ---------------------------------------------------------------------------
// LED matrix scan driver back end
// Frame store, clearing pass and the column shift / latch sequencer.
// ---------------------------------------------------------------------------
module lmsd_back #(
  parameter int PANEL_COLUMNS = lmsd_pkg::PANEL_COLUMNS,
  parameter int SCAN_ROWS     = lmsd_pkg::SCAN_ROWS,
  parameter int PWM_LEVELS    = lmsd_pkg::PWM_LEVELS,
  parameter int CHANNEL_BITS  = lmsd_pkg::CHANNEL_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  input  lmsd_pkg::cmd_t                    cmd_i,
  output logic                              cmd_pop_o,
  input  logic [lmsd_pkg::RES_CNT_W-1:0]    res_cnt_i,
  output logic                              res_push_o,
  output lmsd_pkg::res_t                    res_o,
  output logic                              clearing_o
);

  localparam int COL_W     = $clog2(PANEL_COLUMNS);
  localparam int ROW_W     = $clog2(SCAN_ROWS);
  localparam int AW        = ROW_W + COL_W;
  localparam int MEM_DEPTH = 2 ** AW;
  localparam int PH_W      = $clog2(PWM_LEVELS);
  localparam int LVL_W     = 3 * CHANNEL_BITS;
  localparam int RC_W      = lmsd_pkg::RES_CNT_W + 1;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(PANEL_COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCAN_ROWS - 1);
  localparam logic [PH_W-1:0]  LAST_PH  = PH_W'(PWM_LEVELS - 1);
  localparam logic [AW-1:0]    CLR_LAST = AW'(MEM_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SHIFT,
    ST_LATCH
  } state_e;

  state_e            state_q;
  logic [AW-1:0]     clr_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [PH_W-1:0]   phase_q;
  logic              s1_q;

  logic [LVL_W-1:0]  upper_mem [MEM_DEPTH];
  logic [LVL_W-1:0]  lower_mem [MEM_DEPTH];
  logic [LVL_W-1:0]  rd_upper_q, rd_lower_q;

  logic              clearing, room, rd_en, latch_go, wr_cmd, lower_sel;
  logic              we_upper, we_lower;
  logic [ROW_W-1:0]  row_idx;
  logic [AW-1:0]     waddr, raddr;
  logic [LVL_W-1:0]  wdata;

  assign clearing   = (state_q == ST_CLEAR);
  assign clearing_o = clearing;

  // reserve a result slot for the read in flight
  assign room = (RC_W'(res_cnt_i) + RC_W'(s1_q)) < RC_W'(lmsd_pkg::RES_DEPTH);

  assign rd_en     = (state_q == ST_SHIFT) && room;
  assign latch_go  = (state_q == ST_LATCH) && !s1_q && room;
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign wr_cmd    = cmd_pop_o && !cmd_i.is_tick && cmd_i.in_range;

  // frame rows split into the upper and lower half stores
  always_comb begin
    lower_sel = (32'(cmd_i.pixel_row) >= SCAN_ROWS);
    row_idx   = lower_sel ? ROW_W'(32'(cmd_i.pixel_row) - SCAN_ROWS)
                          : ROW_W'(cmd_i.pixel_row);
    we_upper  = clearing || (wr_cmd && !lower_sel);
    we_lower  = clearing || (wr_cmd && lower_sel);
    waddr     = clearing ? clr_q : {row_idx, COL_W'(cmd_i.pixel_column)};
    wdata     = clearing ? '0
                         : {CHANNEL_BITS'(cmd_i.red), CHANNEL_BITS'(cmd_i.green),
                            CHANNEL_BITS'(cmd_i.blue)};
    raddr     = {row_q, col_q};
  end

  always_ff @(posedge clk_i) begin
    if (we_upper) begin
      upper_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_upper_q <= upper_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_lower) begin
      lower_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_lower_q <= lower_mem[raddr];
    end
  end

  // result word: column bits from read data, else the latch step
  always_comb begin
    res_push_o = s1_q || latch_go;
    res_o      = '0;
    if (s1_q) begin
      res_o.kind        = lmsd_pkg::KIND_COLUMN;
      res_o.upper_red   = 32'(rd_upper_q[LVL_W-1 -: CHANNEL_BITS]) > 32'(phase_q);
      res_o.upper_green = 32'(rd_upper_q[2*CHANNEL_BITS-1 -: CHANNEL_BITS]) > 32'(phase_q);
      res_o.upper_blue  = 32'(rd_upper_q[CHANNEL_BITS-1:0]) > 32'(phase_q);
      res_o.lower_red   = 32'(rd_lower_q[LVL_W-1 -: CHANNEL_BITS]) > 32'(phase_q);
      res_o.lower_green = 32'(rd_lower_q[2*CHANNEL_BITS-1 -: CHANNEL_BITS]) > 32'(phase_q);
      res_o.lower_blue  = 32'(rd_lower_q[CHANNEL_BITS-1:0]) > 32'(phase_q);
    end else begin
      res_o.kind        = lmsd_pkg::KIND_LATCH;
      res_o.row_address = lmsd_pkg::ADDR_FIELD_W'(row_q);
      res_o.last        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= '0;
      s1_q    <= 1'b0;
    end else begin
      s1_q <= rd_en;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == CLR_LAST) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid_i && cmd_i.is_tick) begin
            col_q   <= LAST_COL;
            state_q <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (room) begin
            if (col_q == '0) begin
              state_q <= ST_LATCH;
            end else begin
              col_q <= col_q - COL_W'(1);
            end
          end
        end
        ST_LATCH: begin
          if (latch_go) begin
            state_q <= ST_IDLE;
            if (row_q == LAST_ROW) begin
              row_q   <= '0;
              phase_q <= (phase_q == LAST_PH) ? '0 : phase_q + PH_W'(1);
            end else begin
              row_q <= row_q + ROW_W'(1);
            end
          end
        end
      endcase
    end
  end

endmodule

// ===== design/lmsd_res_fifo.sv =====
// ---------------------------------------------------------------------------
// LED matrix scan driver result queue
// Small queue that holds finished results until popped.
// ---------------------------------------------------------------------------
module lmsd_res_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  lmsd_pkg::res_t                 data_i,
  input  logic                           pop_i,
  output logic                           empty_o,
  output lmsd_pkg::res_t                 data_o,
  output logic [lmsd_pkg::RES_CNT_W-1:0] cnt_o
);

  localparam int PTR_W = $clog2(lmsd_pkg::RES_DEPTH);

  lmsd_pkg::res_t                 slot_q [lmsd_pkg::RES_DEPTH];
  logic [PTR_W-1:0]               wptr_q, rptr_q;
  logic [lmsd_pkg::RES_CNT_W-1:0] cnt_q;
  logic                           do_pop;

  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rptr_q];
  assign cnt_o   = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= PTR_W'((32'(wptr_q) + 1) % lmsd_pkg::RES_DEPTH);
      end
      if (do_pop) begin
        rptr_q <= PTR_W'((32'(rptr_q) + 1) % lmsd_pkg::RES_DEPTH);
      end
      cnt_q <= cnt_q + lmsd_pkg::RES_CNT_W'(push_i) - lmsd_pkg::RES_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== design/led_matrix_scan_pwm_driver.sv =====
// ---------------------------------------------------------------------------
// LED matrix scan PWM driver
// Two-half scanned RGB panel driver with frame store and PWM row refresh.
// ---------------------------------------------------------------------------
// Usage:
//  - Requests enter through push/full. opcode 0 stores one pixel (no result),
//    opcode 1 runs one refresh tick for the current scan row.
//  - Results leave through empty/pop. A tick yields one column word per panel
//    column, highest column first, then one latch word (kind 1, blanked
//    colour bits, row address, last set).
//  - A request is registered in the front queue before the back end takes
//    it. The back end stores a pixel write as it takes it. A tick takes one
//    frame store read per column at one a cycle while the result queue has
//    room, then drains the read stage, then emits the latch word. The first
//    column word passes the front queue, the idle and shift states of the
//    sequencer, the read register and the result queue before it is visible.
//  - Throughput is bounded by the single read port of the frame store.
//  - After reset the frame store is zeroed by a clearing pass over every
//    address of both half stores; full stays high until it ends.
//  - If the receiver stops popping, the result queue fills, the sequencer
//    waits, then the front queue fills and full rises. Nothing is dropped.
// ---------------------------------------------------------------------------
`include "led_matrix_scan_pwm_driver_macros.svh"

module led_matrix_scan_pwm_driver #(
  parameter int PANEL_COLUMNS = lmsd_pkg::PANEL_COLUMNS,
  parameter int SCAN_ROWS     = lmsd_pkg::SCAN_ROWS,
  parameter int PWM_LEVELS    = lmsd_pkg::PWM_LEVELS,
  parameter int CHANNEL_BITS  = lmsd_pkg::CHANNEL_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                push,
  output logic                                full,
  input  logic                                opcode_i,
  input  logic [lmsd_pkg::ROW_FIELD_W-1:0]    pixel_row_i,
  input  logic [lmsd_pkg::COL_FIELD_W-1:0]    pixel_column_i,
  input  logic [lmsd_pkg::LEVEL_FIELD_W-1:0]  red_level_i,
  input  logic [lmsd_pkg::LEVEL_FIELD_W-1:0]  green_level_i,
  input  logic [lmsd_pkg::LEVEL_FIELD_W-1:0]  blue_level_i,
  // result channel
  output logic                                empty,
  input  logic                                pop,
  output logic                                kind_o,
  output logic                                upper_red_o,
  output logic                                upper_green_o,
  output logic                                upper_blue_o,
  output logic                                lower_red_o,
  output logic                                lower_green_o,
  output logic                                lower_blue_o,
  output logic [lmsd_pkg::ADDR_FIELD_W-1:0]   row_address_o,
  output logic                                last_o
);

  logic                           clearing;
  logic                           cmd_valid, cmd_pop;
  lmsd_pkg::cmd_t                 cmd;
  logic                           res_push;
  lmsd_pkg::res_t                 res_in, res_out;
  logic [lmsd_pkg::RES_CNT_W-1:0] res_cnt;
  logic                           colour_lit;

  // front: take and classify requests, hold them in a short queue
  lmsd_front #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .SCAN_ROWS     (SCAN_ROWS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .hold_i         (clearing),
    .opcode_i       (opcode_i),
    .pixel_row_i    (pixel_row_i),
    .pixel_column_i (pixel_column_i),
    .red_level_i    (red_level_i),
    .green_level_i  (green_level_i),
    .blue_level_i   (blue_level_i),
    .full_o         (full),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  // back: frame store and scan sequencer
  lmsd_back #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .SCAN_ROWS     (SCAN_ROWS),
    .PWM_LEVELS    (PWM_LEVELS),
    .CHANNEL_BITS  (CHANNEL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_cnt_i   (res_cnt),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .clearing_o  (clearing)
  );

  // results wait here so the sequencer keeps going while the sink stalls
  lmsd_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out),
    .cnt_o   (res_cnt)
  );

  assign kind_o        = (res_out.kind == lmsd_pkg::KIND_LATCH);
  assign upper_red_o   = res_out.upper_red;
  assign upper_green_o = res_out.upper_green;
  assign upper_blue_o  = res_out.upper_blue;
  assign lower_red_o   = res_out.lower_red;
  assign lower_green_o = res_out.lower_green;
  assign lower_blue_o  = res_out.lower_blue;
  assign row_address_o = res_out.row_address;
  assign last_o        = res_out.last;

  // any colour bit lit on the head word
  assign colour_lit = upper_red_o || upper_green_o || upper_blue_o ||
                      lower_red_o || lower_green_o || lower_blue_o;

  // only the latch word closes a tick
  `LMSD_ASSERT(a_last_is_latch, (!empty |-> (last_o == kind_o)), "last without latch")
  // latch word is blanked
  `LMSD_ASSERT(a_latch_blank, ((!empty && kind_o) |-> !colour_lit), "latch word not blanked")
  // slot reservation keeps the result queue from overflowing
  `LMSD_NEVER(a_res_overflow, (res_push && (res_cnt == lmsd_pkg::RES_FULL)), "result queue overflow")
  // no request may reach the back end during the clearing pass
  `LMSD_NEVER(a_clear_no_cmd, (clearing && cmd_valid), "request queued during clear")

endmodule

// ===== tb/sv/led_matrix_scan_pwm_driver_tb.sv =====
// ---------------------------------------------------------------------------
// LED matrix scan PWM driver testbench
// Feeds pixel writes and refresh ticks through the request queue, predicts
// every column and latch word from a shadow frame store, scan row and PWM
// phase, and checks each popped word field by field in order.
// ---------------------------------------------------------------------------
module led_matrix_scan_pwm_driver_tb;
  import lmsd_pkg::*;

  localparam int          FRAME_ROWS     = 2 * SCAN_ROWS;
  localparam int          WORDS_PER_TICK = PANEL_COLUMNS + 1;
  localparam int          BACKLOG_CYCLES = 600;  // receiver hold-off, long enough to fill up
  localparam int          SETTLE_CYCLES  = 64;   // tail after the last word
  localparam int          RANDOM_REQS    = 386;
  localparam logic [LEVEL_FIELD_W-1:0] LEVEL_MASK = LEVEL_FIELD_W'((1 << CHANNEL_BITS) - 1);

  // traffic shaping per stretch of the run
  typedef enum logic [1:0] {
    PACE_MIXED,    // sender idles 32%, receiver 46%
    PACE_SWAPPED,  // sender idles 46%, receiver 32%
    PACE_STREAM    // nobody idles
  } pace_e;

  typedef struct {
    opcode_e                  op;
    logic [ROW_FIELD_W-1:0]   pixel_row;
    logic [COL_FIELD_W-1:0]   pixel_column;
    logic [LEVEL_FIELD_W-1:0] red;
    logic [LEVEL_FIELD_W-1:0] green;
    logic [LEVEL_FIELD_W-1:0] blue;
    pace_e                    pace;
    logic                     drain_first;  // hold this request until all words are back
    logic                     backlog;      // starts the long receiver hold-off
  } panel_req_t;

  typedef struct packed {
    logic [LEVEL_FIELD_W-1:0] red;
    logic [LEVEL_FIELD_W-1:0] green;
    logic [LEVEL_FIELD_W-1:0] blue;
  } pixel_levels_t;

  // clock, reset and DUT ports; every input is known from time 0
  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     push           = 1'b0;
  logic                     full;
  logic                     opcode_i       = 1'b0;
  logic [ROW_FIELD_W-1:0]   pixel_row_i    = '0;
  logic [COL_FIELD_W-1:0]   pixel_column_i = '0;
  logic [LEVEL_FIELD_W-1:0] red_level_i    = '0;
  logic [LEVEL_FIELD_W-1:0] green_level_i  = '0;
  logic [LEVEL_FIELD_W-1:0] blue_level_i   = '0;
  logic                     empty;
  logic                     pop            = 1'b0;
  logic                     kind_o;
  logic                     upper_red_o;
  logic                     upper_green_o;
  logic                     upper_blue_o;
  logic                     lower_red_o;
  logic                     lower_green_o;
  logic                     lower_blue_o;
  logic [ADDR_FIELD_W-1:0]  row_address_o;
  logic                     last_o;

  // shadow of the panel state
  pixel_levels_t shadow_frame [FRAME_ROWS][PANEL_COLUMNS];
  int unsigned   shadow_scan_row;
  int unsigned   shadow_pwm_phase;

  panel_req_t  pending_reqs[$];   // requests not yet accepted
  res_t        expected_words[$]; // predicted words not yet popped
  int unsigned words_predicted = 0;
  int unsigned words_checked   = 0;
  int unsigned fail_count      = 0;
  pace_e       traffic_pace    = PACE_STREAM;
  logic        backlog_kick    = 1'b0;
  logic        backlog_started = 1'b0;
  int unsigned rx_hold_left    = 0;
  int unsigned ticks_queued    = 0;  // lets random writes aim at upcoming scan rows

  led_matrix_scan_pwm_driver i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .opcode_i       (opcode_i),
    .pixel_row_i    (pixel_row_i),
    .pixel_column_i (pixel_column_i),
    .red_level_i    (red_level_i),
    .green_level_i  (green_level_i),
    .blue_level_i   (blue_level_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .upper_red_o    (upper_red_o),
    .upper_green_o  (upper_green_o),
    .upper_blue_o   (upper_blue_o),
    .lower_red_o    (lower_red_o),
    .lower_green_o  (lower_green_o),
    .lower_blue_o   (lower_blue_o),
    .row_address_o  (row_address_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned idle_pct(pace_e pace, bit sender);
    case (pace)
      PACE_MIXED:   return sender ? 32 : 46;
      PACE_SWAPPED: return sender ? 46 : 32;
      default:      return 0;
    endcase
  endfunction

  // Updates the shadow state for one accepted request and queues the words
  // it should produce. Returns how many words were queued.
  function automatic int unsigned predict_scan_words(panel_req_t req);
    res_t        word;
    int unsigned lower_row;
    if (req.op == OP_WRITE) begin
      // out-of-range pixels are dropped (unreachable at the default size)
      if (req.pixel_row < FRAME_ROWS && req.pixel_column < PANEL_COLUMNS) begin
        shadow_frame[req.pixel_row][req.pixel_column] =
          '{req.red & LEVEL_MASK, req.green & LEVEL_MASK, req.blue & LEVEL_MASK};
      end
      return 0;
    end
    lower_row = shadow_scan_row + SCAN_ROWS;
    // column words go out highest column first; a bit is lit when the
    // level is strictly above the current PWM phase
    for (int col = PANEL_COLUMNS - 1; col >= 0; col--) begin
      word             = '0;
      word.kind        = KIND_COLUMN;
      word.upper_red   = shadow_frame[shadow_scan_row][col].red   > shadow_pwm_phase;
      word.upper_green = shadow_frame[shadow_scan_row][col].green > shadow_pwm_phase;
      word.upper_blue  = shadow_frame[shadow_scan_row][col].blue  > shadow_pwm_phase;
      word.lower_red   = shadow_frame[lower_row][col].red         > shadow_pwm_phase;
      word.lower_green = shadow_frame[lower_row][col].green       > shadow_pwm_phase;
      word.lower_blue  = shadow_frame[lower_row][col].blue        > shadow_pwm_phase;
      expected_words.push_back(word);
    end
    // latch word: colour blanked, address of the row just shifted
    word             = '0;
    word.kind        = KIND_LATCH;
    word.row_address = ADDR_FIELD_W'(shadow_scan_row);
    word.last        = 1'b1;
    expected_words.push_back(word);
    // row advances; the PWM phase steps on each wrap of the scan
    if (shadow_scan_row == SCAN_ROWS - 1) begin
      shadow_scan_row  = 0;
      shadow_pwm_phase = (shadow_pwm_phase + 1) % PWM_LEVELS;
    end else begin
      shadow_scan_row++;
    end
    return WORDS_PER_TICK;
  endfunction

  function automatic void add_request(opcode_e op, int unsigned row, int unsigned col,
                                      int unsigned red, int unsigned green,
                                      int unsigned blue, pace_e pace);
    panel_req_t req;
    req.op           = op;
    req.pixel_row    = ROW_FIELD_W'(row);
    req.pixel_column = COL_FIELD_W'(col);
    req.red          = LEVEL_FIELD_W'(red);
    req.green        = LEVEL_FIELD_W'(green);
    req.blue         = LEVEL_FIELD_W'(blue);
    req.pace         = pace;
    req.drain_first  = 1'b0;
    req.backlog      = 1'b0;
    pending_reqs.push_back(req);
    if (op == OP_TICK) ticks_queued++;
  endfunction

  // levels near the PWM phases matter most, full range for the rest
  function automatic int unsigned random_level();
    return ($urandom_range(0, 1) == 0) ? $urandom_range(0, PWM_LEVELS)
                                       : $urandom_range(0, 255);
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // -------------------------------------------------------------------------
  // Request driver: offers the head of pending_reqs, predicts on acceptance.
  // -------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    panel_req_t  head;
    int unsigned new_words;
    logic        offer;
    if (!rst_ni) begin
      push           <= 1'b0;
      opcode_i       <= OP_WRITE;
      pixel_row_i    <= '0;
      pixel_column_i <= '0;
      red_level_i    <= '0;
      green_level_i  <= '0;
      blue_level_i   <= '0;
    end else begin
      new_words = 0;
      if (push && !full) begin
        head      = pending_reqs.pop_front();
        new_words = predict_scan_words(head);
        words_predicted <= words_predicted + new_words;
      end
      // a new request may go up only when the previous one is gone
      if (!push || !full) begin
        offer = 1'b0;
        if (pending_reqs.size() != 0) begin
          head  = pending_reqs[0];
          offer = 1'b1;
          // pause until every outstanding word has been popped
          if (head.drain_first && (words_predicted + new_words != words_checked))
            offer = 1'b0;
          else if ($urandom_range(0, 99) < idle_pct(head.pace, 1'b1))
            offer = 1'b0;
        end
        push <= offer;
        if (offer) begin
          opcode_i       <= head.op;
          pixel_row_i    <= head.pixel_row;
          pixel_column_i <= head.pixel_column;
          red_level_i    <= head.red;
          green_level_i  <= head.green;
          blue_level_i   <= head.blue;
          traffic_pace   <= head.pace;
          if (head.backlog) backlog_kick <= 1'b1;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result monitor: pops words and checks them against the oldest prediction.
  // -------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          $error("result word popped with no request outstanding");
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("kind",        8'(want.kind),        8'(kind_o));
          check_field("upper_red",   8'(want.upper_red),   8'(upper_red_o));
          check_field("upper_green", 8'(want.upper_green), 8'(upper_green_o));
          check_field("upper_blue",  8'(want.upper_blue),  8'(upper_blue_o));
          check_field("lower_red",   8'(want.lower_red),   8'(lower_red_o));
          check_field("lower_green", 8'(want.lower_green), 8'(lower_green_o));
          check_field("lower_blue",  8'(want.lower_blue),  8'(lower_blue_o));
          check_field("row_address", 8'(want.row_address), 8'(row_address_o));
          check_field("last",        8'(want.last),        8'(last_o));
          words_checked <= words_checked + 1;
        end
      end
      // one long hold-off so the result and request queues back up
      if (backlog_kick && !backlog_started) begin
        backlog_started <= 1'b1;
        rx_hold_left    <= BACKLOG_CYCLES;
        pop             <= 1'b0;
      end else if (rx_hold_left != 0) begin
        rx_hold_left <= rx_hold_left - 1;
        pop          <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= idle_pct(traffic_pace, 1'b0));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus and end of run
  // -------------------------------------------------------------------------
  initial begin
    pace_e       pace;
    int unsigned row;
    for (int r = 0; r < FRAME_ROWS; r++)
      for (int c = 0; c < PANEL_COLUMNS; c++)
        shadow_frame[r][c] = '0;
    shadow_scan_row  = 0;
    shadow_pwm_phase = 0;

    // directed: tick on a cleared frame, then corner pixels with levels
    // straddling phase 0, channel extremes in both halves
    add_request(OP_TICK,  0,  0, 8'h00, 8'h00, 8'h00, PACE_STREAM);
    add_request(OP_WRITE, 0, 31, 8'hFF, 8'h00, 8'h01, PACE_STREAM);
    add_request(OP_WRITE, 16, 0, 8'h01, 8'hFF, 8'h00, PACE_STREAM);
    add_request(OP_WRITE, 0,  0, 8'h80, 8'h7F, 8'h08, PACE_STREAM);
    add_request(OP_WRITE, 16, 31, 8'h07, 8'h08, 8'hFF, PACE_STREAM);
    add_request(OP_WRITE, 15, 31, 8'h55, 8'hAA, 8'h02, PACE_STREAM);
    add_request(OP_WRITE, 31, 0, 8'hAA, 8'h55, 8'h00, PACE_STREAM);
    add_request(OP_WRITE, 1, 21, 8'h3C, 8'hC3, 8'h01, PACE_STREAM);
    // sweep the remaining scan rows so the phase wraps; the receiver stalls
    // at the start while ticks keep coming
    for (int i = 0; i < SCAN_ROWS - 1; i++) begin
      add_request(OP_TICK, 0, 0, 8'h00, 8'h00, 8'h00, PACE_STREAM);
      if (i == 0) pending_reqs[$].backlog = 1'b1;
    end
    // row 0 at phase 1: a level of 1 goes dark; sender waits for a full drain
    add_request(OP_WRITE, 0, 31, 8'h01, 8'h02, 8'hFF, PACE_STREAM);
    pending_reqs[$].drain_first = 1'b1;
    add_request(OP_TICK,  0, 0, 8'h00, 8'h00, 8'h00, PACE_STREAM);

    // random: mostly ticks, writes often aimed at the next rows to be scanned
    for (int i = 0; i < RANDOM_REQS; i++) begin
      pace = (i < RANDOM_REQS / 3)     ? PACE_MIXED :
             (i < 2 * RANDOM_REQS / 3) ? PACE_SWAPPED : PACE_STREAM;
      if ($urandom_range(0, 99) < 55) begin
        add_request(OP_TICK, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), pace);
      end else begin
        row = ($urandom_range(0, 1) == 0)
                ? (ticks_queued + $urandom_range(0, 2)) % SCAN_ROWS
                  + SCAN_ROWS * $urandom_range(0, 1)
                : $urandom_range(0, 31);
        add_request(OP_WRITE, row, $urandom_range(0, 31),
                    random_level(), random_level(), random_level(), pace);
      end
      if (i == RANDOM_REQS / 3 || i == 2 * RANDOM_REQS / 3)
        pending_reqs[$].drain_first = 1'b1;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || push) @(posedge clk_i);
    while (words_checked != words_predicted) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      $error("%0d predicted words never arrived", expected_words.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run including the clearing pass
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
